[design/assert_macros.svh]
// assertion helpers for the design files, included by interval_reservation_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/irt_pkg.sv]
// ---------------------------------------------------------------------------
// irt_pkg
// Types, constants and helper functions of the interval reservation table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

   localparam int POS_W   = 12;
   localparam int VAL_W   = 13;
   localparam int BIT_W   = 6;
   localparam int ROW_W   = POS_W - BIT_W;
   localparam int WORD_W  = 1 << BIT_W;
   localparam int ROWS    = 1 << ROW_W;
   localparam int POSITIONS = 1 << POS_W;

   localparam logic MODE_RESERVE = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_SCAN,
      S_ECHK,
      S_STORE,
      S_SLOAD,
      S_DONE
   } state_type;

   // bitmap memory access from the control unit
   typedef struct packed {
      logic              rd_en;
      logic [ROW_W-1:0]  rd_addr;
      logic              wr_en;
      logic [ROW_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
   } bm_req_type;

   // index of the highest set bit, zero when none
   function automatic logic [BIT_W-1:0] hi_bit(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (v[i]) r = i[BIT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/irt_req_if.sv]
// ---------------------------------------------------------------------------
// irt_req_if
// Request channel: mode, start and end position of one word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface irt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [irt_pkg::POS_W-1:0]     start_pos;
   logic [irt_pkg::POS_W-1:0]     end_pos;

   modport source (output valid, mode, start_pos, end_pos, input ready);
   modport sink   (input valid, mode, start_pos, end_pos, output ready);
endinterface

`default_nettype wire

[design/irt_rsp_if.sv]
// ---------------------------------------------------------------------------
// irt_rsp_if
// Response channel: one count value per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface irt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [irt_pkg::VAL_W-1:0]     value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

[design/interval_reservation_table.sv]
// ---------------------------------------------------------------------------
// interval_reservation_table
// Set of disjoint reserved intervals with evicting insert and count query.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per item: mode (0 reserve, 1 query),
//   start_pos and end_pos. rsp_chan returns one word per item: value, the
//   number of intervals evicted by a reserve or held at a query.
//   A query goes from accept straight to the done step, which raises its
//   response and frees the input for the next word at the same edge.
//   A reserve walks the start bitmap downward from end_pos: each bitmap
//   row is read, loaded and scanned, and each active start found is checked
//   against its end in the end memory (the evicted ones and the one that
//   ends the walk). The walk ends there or on a scan that finds nothing;
//   the new interval's bitmap row is then read and written back with its
//   start set, its end is stored, and the response is raised.
//   One item is in work at a time; a new word is taken while the previous
//   response still waits.
//   Reset clears the row summary and the held count, so the table is
//   empty at once; no clearing pass is needed.
//   When the receiver stalls, the response register holds its word and
//   the item in work waits at its last step until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module interval_reservation_table (
   input  wire logic clock,
   input  wire logic reset,
   irt_req_if.sink   req_chan,
   irt_rsp_if.source rsp_chan
);

   irt_pkg::state_type              state_ff, state_in;
   logic [irt_pkg::POS_W-1:0]       s_ff, s_in, e_ff, e_in;
   logic [irt_pkg::ROW_W-1:0]       cw_ff, cw_in;
   logic [irt_pkg::BIT_W-1:0]       cb_ff, cb_in;
   logic [irt_pkg::WORD_W-1:0]      word_ff, word_in;
   logic [irt_pkg::VAL_W-1:0]       evict_ff, evict_in;
   logic [irt_pkg::VAL_W-1:0]       held_ff, held_in;
   logic [irt_pkg::VAL_W-1:0]       value_ff, value_in;
   logic                            is_query_ff, is_query_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   irt_pkg::bm_req_type             bm_req;
   logic [irt_pkg::WORD_W-1:0]      bm_rdata;
   logic [irt_pkg::ROWS-1:0]        summary;
   logic                            end_rd_en, end_wr_en;
   logic [irt_pkg::POS_W-1:0]       end_rd_addr, end_rdata;

   logic [irt_pkg::WORD_W-1:0]      masked, below, sbit;
   logic [irt_pkg::BIT_W-1:0]       hit_bit;
   logic                            accept, rsp_free;

   irt_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .bm_req  (bm_req),
      .rd_data (bm_rdata),
      .summary (summary)
   );

   irt_end_mem u_end_mem (
      .clock   (clock),
      .rd_en   (end_rd_en),
      .rd_addr (end_rd_addr),
      .rd_data (end_rdata),
      .wr_en   (end_wr_en),
      .wr_addr (s_ff),
      .wr_data (e_ff)
   );

   assign req_chan.ready = (state_ff == irt_pkg::S_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = value_ff;

   // search helpers
   always_comb begin
      masked  = word_ff & ({irt_pkg::WORD_W{1'b1}} >> (~cb_ff));
      below   = summary & ((irt_pkg::WORD_W'(1) << cw_ff) - irt_pkg::WORD_W'(1));
      hit_bit = irt_pkg::hi_bit(masked);
      sbit    = irt_pkg::WORD_W'(1) << s_ff[irt_pkg::BIT_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         irt_pkg::S_IDLE:  if (accept) begin
            state_in = (req_chan.mode == irt_pkg::MODE_QUERY) ? irt_pkg::S_DONE
                                                              : irt_pkg::S_READ;
         end
         irt_pkg::S_READ:  state_in = irt_pkg::S_LOAD;
         irt_pkg::S_LOAD:  state_in = irt_pkg::S_SCAN;
         irt_pkg::S_SCAN: begin
            if (|masked)     state_in = irt_pkg::S_ECHK;
            else if (|below) state_in = irt_pkg::S_READ;
            else             state_in = irt_pkg::S_STORE;
         end
         irt_pkg::S_ECHK:  state_in = (end_rdata >= s_ff) ? irt_pkg::S_SCAN
                                                          : irt_pkg::S_STORE;
         irt_pkg::S_STORE: state_in = irt_pkg::S_SLOAD;
         irt_pkg::S_SLOAD: state_in = irt_pkg::S_DONE;
         irt_pkg::S_DONE:  if (rsp_free) state_in = irt_pkg::S_IDLE;
         default:          state_in = irt_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      s_in         = s_ff;
      e_in         = e_ff;
      cw_in        = cw_ff;
      cb_in        = cb_ff;
      word_in      = word_ff;
      evict_in     = evict_ff;
      held_in      = held_ff;
      value_in     = value_ff;
      is_query_in  = is_query_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      bm_req       = '0;
      end_rd_en    = 1'b0;
      end_rd_addr  = {cw_ff, hit_bit};
      end_wr_en    = 1'b0;
      case (state_ff)
         irt_pkg::S_IDLE: if (accept) begin
            s_in        = req_chan.start_pos;
            e_in        = req_chan.end_pos;
            cw_in       = req_chan.end_pos[irt_pkg::POS_W-1:irt_pkg::BIT_W];
            cb_in       = req_chan.end_pos[irt_pkg::BIT_W-1:0];
            evict_in    = '0;
            is_query_in = (req_chan.mode == irt_pkg::MODE_QUERY);
         end
         irt_pkg::S_READ: begin
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = cw_ff;
         end
         irt_pkg::S_LOAD: word_in = bm_rdata;
         irt_pkg::S_SCAN: begin
            if (|masked) begin
               end_rd_en = 1'b1;
               cb_in     = hit_bit;
            end else if (|below) begin
               cw_in = irt_pkg::hi_bit(below);
               cb_in = '1;
            end
         end
         irt_pkg::S_ECHK: if (end_rdata >= s_ff) begin
            // evict: clear the start mark and keep scanning this row
            word_in        = word_ff & ~(irt_pkg::WORD_W'(1) << cb_ff);
            bm_req.wr_en   = 1'b1;
            bm_req.wr_addr = cw_ff;
            bm_req.wr_data = word_ff & ~(irt_pkg::WORD_W'(1) << cb_ff);
            evict_in       = evict_ff + 1'b1;
            held_in        = held_ff - 1'b1;
         end
         irt_pkg::S_STORE: begin
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = s_ff[irt_pkg::POS_W-1:irt_pkg::BIT_W];
         end
         irt_pkg::S_SLOAD: begin
            bm_req.wr_en   = 1'b1;
            bm_req.wr_addr = s_ff[irt_pkg::POS_W-1:irt_pkg::BIT_W];
            bm_req.wr_data = bm_rdata | sbit;
            end_wr_en      = 1'b1;
            if (!(|(bm_rdata & sbit))) held_in = held_ff + 1'b1;
         end
         irt_pkg::S_DONE: if (rsp_free) begin
            rsp_valid_in = 1'b1;
            value_in     = is_query_ff ? held_ff : evict_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irt_pkg::S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      e_ff        <= e_in;
      cw_ff       <= cw_in;
      cb_ff       <= cb_in;
      word_ff     <= word_in;
      evict_ff    <= evict_in;
      value_ff    <= value_in;
      is_query_ff <= is_query_in;
   end

   // checks
   `ASSERT_CLK(a_held_bound, clock, reset, held_ff <= irt_pkg::VAL_W'(irt_pkg::POSITIONS), "held count above table size")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == irt_pkg::S_DONE), "response raised outside done step")
   `ASSERT_CLK(a_evict_bound, clock, reset, (state_ff == irt_pkg::S_DONE && !is_query_ff) |-> evict_ff <= irt_pkg::VAL_W'(irt_pkg::POSITIONS), "eviction count out of range")

endmodule

`default_nettype wire

[design/irt_bitmap.sv]
// ---------------------------------------------------------------------------
// irt_bitmap
// Start bitmap held as rows of bits in a memory, with a per-row summary
// register that marks rows holding any set bit. Unmarked rows read as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irt_bitmap (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire irt_pkg::bm_req_type             bm_req,
   output logic [irt_pkg::WORD_W-1:0]           rd_data,
   output logic [irt_pkg::ROWS-1:0]             summary
);

   logic [irt_pkg::WORD_W-1:0] mem [irt_pkg::ROWS];
   logic [irt_pkg::WORD_W-1:0] rdata_ff;
   logic                       rvalid_ff;
   logic [irt_pkg::ROWS-1:0]   summary_ff;

   // memory port
   always_ff @(posedge clock) begin
      if (bm_req.wr_en) mem[bm_req.wr_addr] <= bm_req.wr_data;
      if (bm_req.rd_en) rdata_ff <= mem[bm_req.rd_addr];
   end

   // row summary, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         summary_ff <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         if (bm_req.wr_en) summary_ff[bm_req.wr_addr] <= |bm_req.wr_data;
         if (bm_req.rd_en) rvalid_ff <= summary_ff[bm_req.rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;
   assign summary = summary_ff;

endmodule

`default_nettype wire

[design/irt_end_mem.sv]
// ---------------------------------------------------------------------------
// irt_end_mem
// End position of each interval, addressed by its start position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irt_end_mem (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [irt_pkg::POS_W-1:0]   rd_addr,
   output logic [irt_pkg::POS_W-1:0]        rd_data,
   input  wire logic                        wr_en,
   input  wire logic [irt_pkg::POS_W-1:0]   wr_addr,
   input  wire logic [irt_pkg::POS_W-1:0]   wr_data
);

   logic [irt_pkg::POS_W-1:0] mem [irt_pkg::POSITIONS];
   logic [irt_pkg::POS_W-1:0] rdata_ff;

   // single read, single write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

[verif/tb_interval_reservation_table.sv]
// ---------------------------------------------------------------------------
// tb_interval_reservation_table
// Self-checking bench: random and directed reserve/query words are sent,
// each response is compared with a model of the interval table kept here.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_interval_reservation_table;

   logic clock;
   logic reset;
   int   fail_count;
   int   word_count;
   int   rsp_count;
   bit   no_idle;

   irt_req_if req_chan ();
   irt_rsp_if rsp_chan ();

   interval_reservation_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // table model
   bit                          mark_set [irt_pkg::POSITIONS];
   logic [irt_pkg::POS_W-1:0]   mark_end [irt_pkg::POSITIONS];
   logic [irt_pkg::VAL_W-1:0]   held;
   logic [irt_pkg::VAL_W-1:0]   expected_values [$];

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [irt_pkg::VAL_W-1:0] table_apply(logic mode,
                                                             logic [irt_pkg::POS_W-1:0] s,
                                                             logic [irt_pkg::POS_W-1:0] e);
      int                        i;
      logic [irt_pkg::VAL_W-1:0] evicted;
      evicted = '0;
      if (mode == irt_pkg::MODE_QUERY) return held;
      // downward walk over active starts, stop at first non-overlap
      for (i = int'(e); i >= 0; i--) begin
         if (mark_set[i]) begin
            if (mark_end[i] >= s) begin
               mark_set[i] = 1'b0;
               evicted++;
               held--;
            end else begin
               break;
            end
         end
      end
      if (!mark_set[s]) begin
         mark_set[s] = 1'b1;
         held++;
      end
      mark_end[s] = e;
      return evicted;
   endfunction

   task automatic report(string what, logic [irt_pkg::VAL_W-1:0] got,
                         logic [irt_pkg::VAL_W-1:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // send one word, with optional random idle burst first
   task automatic send_word(logic mode, logic [irt_pkg::POS_W-1:0] s,
                            logic [irt_pkg::POS_W-1:0] e);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= mode;
      req_chan.start_pos <= s;
      req_chan.end_pos   <= e;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_values.push_back(table_apply(mode, s, e));
      word_count++;
      @(negedge clock);
   endtask

   // response check at rising edge
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (expected_values.size() == 0) begin
            report("unexpected word", rsp_chan.value, '0);
         end else begin
            logic [irt_pkg::VAL_W-1:0] want;
            want = expected_values.pop_front();
            if (rsp_chan.value !== want) report("value", rsp_chan.value, want);
         end
      end
   end

   // receiver stall bursts
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // stop sending and wait for every expected response
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_values.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_word(irt_pkg::MODE_QUERY, '0, '0);
      send_word(irt_pkg::MODE_RESERVE, 12'd1, 12'd4095);
      send_word(irt_pkg::MODE_RESERVE, 12'd4095, 12'd4095);
      send_word(irt_pkg::MODE_RESERVE, 12'd1, 12'd1);
      send_word(irt_pkg::MODE_QUERY, 12'hFFF, 12'hFFF);
      send_word(irt_pkg::MODE_RESERVE, 12'd10, 12'd20);
      send_word(irt_pkg::MODE_RESERVE, 12'd30, 12'd40);
      send_word(irt_pkg::MODE_RESERVE, 12'd50, 12'd60);
      // spans all three above
      send_word(irt_pkg::MODE_RESERVE, 12'd15, 12'd55);
      // start already active, end rewritten
      send_word(irt_pkg::MODE_RESERVE, 12'd15, 12'd16);
      // start above end
      send_word(irt_pkg::MODE_RESERVE, 12'd100, 12'd90);
      // nothing at or below end
      send_word(irt_pkg::MODE_RESERVE, 12'd2, 12'd0);
      send_word(irt_pkg::MODE_RESERVE, 12'd0, 12'd0);
      send_word(irt_pkg::MODE_RESERVE, 12'd2730, 12'd1365);
      send_word(irt_pkg::MODE_RESERVE, 12'd1365, 12'd2730);
      send_word(irt_pkg::MODE_QUERY, '0, '0);
      send_word(irt_pkg::MODE_RESERVE, 12'd0, 12'd4095);
      send_word(irt_pkg::MODE_QUERY, '0, '0);
   endtask

   // mostly short intervals so the table fills and evictions stay frequent
   task automatic test_random(int count);
      int                        k;
      logic [irt_pkg::POS_W-1:0] s;
      logic [irt_pkg::POS_W-1:0] e;
      for (k = 0; k < count; k++) begin
         s = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 300));
         case ($urandom_range(0, 5))
            0: e = 12'($urandom);
            1: e = s - 12'($urandom_range(0, 5));
            default: e = s + 12'($urandom_range(0, 12));
         endcase
         send_word($urandom_range(0, 6) == 0 ? irt_pkg::MODE_QUERY : irt_pkg::MODE_RESERVE,
                   s, e);
      end
   endtask

   task automatic test_pause_then_query();
      wait_drained();
      send_word(irt_pkg::MODE_QUERY, '0, '0);
   endtask

   initial begin
      fail_count = 0;
      word_count = 0;
      rsp_count  = 0;
      no_idle    = 1'b0;
      held       = '0;
      req_chan.valid     <= 1'b0;
      req_chan.mode      <= irt_pkg::MODE_RESERVE;
      req_chan.start_pos <= '0;
      req_chan.end_pos   <= '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_pause_then_query();
      test_random(450);
      no_idle = 1'b1;
      test_random(80);

      wait_drained();
      repeat (100) @(negedge clock);
      $display("sent %0d words, checked %0d responses; reserves with evictions,",
               word_count, rsp_count);
      $display("rewrites, start above end, extremes and queries covered");
      if (fail_count == 0 && expected_values.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // overall limit
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/irt_pkg.sv
design/irt_req_if.sv
design/irt_rsp_if.sv
design/irt_bitmap.sv
design/irt_end_mem.sv
design/interval_reservation_table.sv
verif/tb_interval_reservation_table.sv
